[src/voxel_frame_buffer_plane_blend_defines.svh]
// Assertion macros shared by the voxel frame buffer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef VOXEL_FRAME_BUFFER_PLANE_BLEND_DEFINES_SVH
`define VOXEL_FRAME_BUFFER_PLANE_BLEND_DEFINES_SVH

// Clocked property, disabled while reset is asserted
`define VFBPB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true at a clock edge
`define VFBPB_NEVER(label, clk, rst_n, expr, msg) \
    `VFBPB_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

[src/vfbpb_pkg.sv]
// Shared types and constants for the voxel frame buffer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vfbpb_pkg;

    // Default cube edge length
    localparam int CUBE_EDGE_DEF = 5;

    // Fixed field widths
    localparam int KIND_W  = 3;
    localparam int COORD_W = 3;
    localparam int VI_W    = 7;
    localparam int AXIS_W  = 2;
    localparam int POS_W   = 5;
    localparam int COLOR_W = 8;
    localparam int MODE_W  = 2;
    localparam int BSIZE_W = 2;
    localparam int PARTS_W = 3;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WR_XYZ     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WR_IDX     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RD_XYZ     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RD_IDX     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PLANE_FILL = 3'd5;
    localparam logic [KIND_W-1:0] KIND_PLANE_ELEM = 3'd6;
    localparam logic [KIND_W-1:0] KIND_BLOCK      = 3'd7;

    // Blend modes
    localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MASK    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AND     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_OR      = 2'd3;

    // Plane normal axes
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // Block part select bits
    localparam int PART_EDGE  = 0;
    localparam int PART_FACE  = 1;
    localparam int PART_INNER = 2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input beat, rewind the sweep
        logic issue;  // visit the current voxel and advance
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;     // sweep counter at the final voxel
        logic is_read;  // captured item returns a result beat
    } t_status;

endpackage

[src/vfbpb_dp.sv]
// Datapath: item registers, voxel sweep counter, voxel match logic,
// read-modify-write stage and the voxel store. Depends on vfbpb_pkg.
`timescale 1ns / 1ps

module vfbpb_dp #(
    parameter int CUBE_EDGE = vfbpb_pkg::CUBE_EDGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vfbpb_pkg::t_cmd                  i_cmd,
    output vfbpb_pkg::t_status               o_status,
    input  logic [vfbpb_pkg::KIND_W-1:0]     i_kind,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_x,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_y,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_z,
    input  logic [vfbpb_pkg::VI_W-1:0]       i_voxel_index,
    input  logic [vfbpb_pkg::AXIS_W-1:0]     i_axis,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_plane_index,
    input  logic [vfbpb_pkg::POS_W-1:0]      i_plane_position,
    input  logic [vfbpb_pkg::COLOR_W-1:0]    i_color,
    input  logic [vfbpb_pkg::MODE_W-1:0]     i_blend_mode,
    input  logic [vfbpb_pkg::BSIZE_W-1:0]    i_block_size,
    input  logic [vfbpb_pkg::PARTS_W-1:0]    i_draw_parts,
    output logic [vfbpb_pkg::COLOR_W-1:0]    o_voxel_color
);
    import vfbpb_pkg::*;

    localparam int VOXELS = CUBE_EDGE * CUBE_EDGE * CUBE_EDGE;
    localparam int CW     = $clog2(CUBE_EDGE);
    localparam int AW     = $clog2(VOXELS);
    localparam int IW     = (AW > VI_W) ? AW : VI_W;
    localparam int PW     = $clog2(CUBE_EDGE * CUBE_EDGE) + 1;
    localparam int CENTER = CUBE_EDGE / 2;
    // block bounds are offset by two so they never go negative
    localparam int BW     = 4;

    // captured item
    logic [KIND_W-1:0]  r_kind;
    logic [COORD_W-1:0] r_x, r_y, r_z, r_k;
    logic [VI_W-1:0]    r_vi;
    logic [AXIS_W-1:0]  r_axis;
    logic [POS_W-1:0]   r_pos;
    logic [COLOR_W-1:0] r_color;
    logic [MODE_W-1:0]  r_mode;
    logic [BSIZE_W-1:0] r_bsize;
    logic [PARTS_W-1:0] r_parts;

    // sweep counter
    logic [CW-1:0] r_cx, r_cy, r_cz;
    logic [AW-1:0] r_addr;
    logic          last;

    // read-modify-write stage
    logic          r_s1_valid;
    logic          r_s1_hit;
    logic [AW-1:0] r_s1_addr;

    // store
    logic [COLOR_W-1:0] r_mem [VOXELS];
    logic [COLOR_W-1:0] r_rd_data;
    logic [COLOR_W-1:0] r_result;

    logic               is_read;
    logic               hit;
    logic               xyz_hit, idx_hit, plane_on, elem_hit, block_hit;
    logic [CW-1:0]      pu, pv;
    logic [PW-1:0]      elem;
    logic [BW-1:0]      lo2, hi2, cx2, cy2, cz2;
    logic               in_x, in_y, in_z, on_x, on_y, on_z;
    logic               is_edge, is_face, part_on;
    logic               we;
    logic [COLOR_W-1:0] wdata;

    assign last    = (r_cx == CW'(CUBE_EDGE - 1)) && (r_cy == CW'(CUBE_EDGE - 1))
                  && (r_cz == CW'(CUBE_EDGE - 1));
    assign is_read = (r_kind == KIND_RD_XYZ) || (r_kind == KIND_RD_IDX);
    assign o_status = '{last: last, is_read: is_read};

    // item capture; the kind resets to clear so reset runs a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_CLEAR;
        end else if (i_cmd.load) begin
            r_kind <= i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x     <= i_x;
            r_y     <= i_y;
            r_z     <= i_z;
            r_vi    <= i_voxel_index;
            r_axis  <= i_axis;
            r_k     <= i_plane_index;
            r_pos   <= i_plane_position;
            r_color <= i_color;
            r_mode  <= i_blend_mode;
            r_bsize <= i_block_size;
            r_parts <= i_draw_parts;
        end
    end

    // sweep counter, x fastest, linear address alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            if (last) begin
                r_cx   <= '0;
                r_cy   <= '0;
                r_cz   <= '0;
                r_addr <= '0;
            end else begin
                r_addr <= r_addr + AW'(1);
                if (r_cx == CW'(CUBE_EDGE - 1)) begin
                    r_cx <= '0;
                    if (r_cy == CW'(CUBE_EDGE - 1)) begin
                        r_cy <= '0;
                        r_cz <= r_cz + CW'(1);
                    end else begin
                        r_cy <= r_cy + CW'(1);
                    end
                end else begin
                    r_cx <= r_cx + CW'(1);
                end
            end
        end
    end

    // single voxel matches
    assign xyz_hit = (COORD_W'(r_cx) == r_x) && (COORD_W'(r_cy) == r_y)
                  && (COORD_W'(r_cz) == r_z);
    assign idx_hit = (IW'(r_addr) == IW'(r_vi));

    // plane membership and in-plane coordinates
    always_comb begin
        pu       = r_cx;
        pv       = r_cy;
        plane_on = 1'b0;
        unique case (r_axis)
            AXIS_X: begin
                pu       = r_cy;
                pv       = r_cz;
                plane_on = (COORD_W'(r_cx) == r_k);
            end
            AXIS_Y: begin
                pu       = r_cx;
                pv       = r_cz;
                plane_on = (COORD_W'(r_cy) == r_k);
            end
            AXIS_Z: begin
                pu       = r_cx;
                pv       = r_cy;
                plane_on = (COORD_W'(r_cz) == r_k);
            end
            default: begin
                plane_on = 1'b0;
            end
        endcase
    end

    assign elem     = PW'(pu) + PW'(pv) * PW'(CUBE_EDGE);
    assign elem_hit = plane_on && (elem == PW'(r_pos));

    // centered block bounds and voxel class
    assign lo2  = BW'(CENTER + 3) - BW'(r_bsize);
    assign hi2  = BW'(CENTER + 1) + BW'(r_bsize);
    assign cx2  = BW'(r_cx) + BW'(2);
    assign cy2  = BW'(r_cy) + BW'(2);
    assign cz2  = BW'(r_cz) + BW'(2);
    assign in_x = (cx2 >= lo2) && (cx2 <= hi2);
    assign in_y = (cy2 >= lo2) && (cy2 <= hi2);
    assign in_z = (cz2 >= lo2) && (cz2 <= hi2);
    assign on_x = (cx2 == lo2) || (cx2 == hi2);
    assign on_y = (cy2 == lo2) || (cy2 == hi2);
    assign on_z = (cz2 == lo2) || (cz2 == hi2);
    assign is_edge = (on_x && on_y) || (on_x && on_z) || (on_y && on_z);
    assign is_face = !is_edge && (on_x || on_y || on_z);
    assign part_on = is_edge ? r_parts[PART_EDGE]
                   : (is_face ? r_parts[PART_FACE] : r_parts[PART_INNER]);
    assign block_hit = (r_bsize != '0) && in_x && in_y && in_z && part_on;

    // does the current voxel take part in this item
    always_comb begin
        unique case (r_kind)
            KIND_CLEAR:                 hit = 1'b1;
            KIND_WR_XYZ, KIND_RD_XYZ:   hit = xyz_hit;
            KIND_WR_IDX, KIND_RD_IDX:   hit = idx_hit;
            KIND_PLANE_FILL:            hit = plane_on;
            KIND_PLANE_ELEM:            hit = elem_hit;
            KIND_BLOCK:                 hit = block_hit;
            default:                    hit = 1'b0;
        endcase
    end

    // stage one carries the address while the old byte is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit  <= hit;
        r_s1_addr <= r_addr;
    end

    // new byte: blend only for plane kinds
    always_comb begin
        unique case (r_kind)
            KIND_CLEAR: begin
                wdata = '0;
            end
            KIND_PLANE_FILL, KIND_PLANE_ELEM: begin
                unique case (r_mode)
                    MODE_REPLACE: wdata = r_color;
                    MODE_MASK:    wdata = (r_color != '0) ? r_color : r_rd_data;
                    MODE_AND:     wdata = r_rd_data & r_color;
                    MODE_OR:      wdata = r_rd_data | r_color;
                    default:      wdata = r_color;
                endcase
            end
            default: begin
                wdata = r_color;
            end
        endcase
    end

    assign we = r_s1_valid && r_s1_hit && !is_read;

    // voxel store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_s1_addr] <= wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    // read result; stays zero when the target is out of range
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_result <= '0;
        end else if (r_s1_valid && r_s1_hit && is_read) begin
            r_result <= r_rd_data;
        end
    end

    assign o_voxel_color = r_result;

endmodule

[src/vfbpb_ctrl.sv]
// Controller: sequences load, voxel sweep, pipeline drain and result beat.
// Depends on vfbpb_pkg.
`timescale 1ns / 1ps

module vfbpb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vfbpb_pkg::t_cmd    o_cmd,
    input  vfbpb_pkg::t_status i_status
);
    import vfbpb_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (i_status.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = i_status.is_read ? ST_RESULT : ST_IDLE;
            end
            ST_RESULT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // reset starts with the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_RESULT);
    assign o_cmd = '{load: (r_state == ST_IDLE) && i_in_valid,
                     issue: (r_state == ST_SWEEP)};

endmodule

[src/voxel_frame_buffer_plane_blend.sv]
// Voxel frame store for a CUBE_EDGE^3 cube of 8-bit colors. Every item
// (clear, voxel write/read, plane fill, plane element, block draw) is done
// by one sweep over all CUBE_EDGE^3 voxels of the store (one read port and
// one write port), one read-modify-write per cycle, and the next input beat
// is accepted only after the sweep and a pipeline drain; read kinds then hold
// one result beat until it is taken. After reset a clearing pass over all
// voxels runs before the first input beat is accepted.
// Depends on vfbpb_pkg, vfbpb_ctrl and vfbpb_dp.
`timescale 1ns / 1ps

module voxel_frame_buffer_plane_blend #(
    parameter int CUBE_EDGE = vfbpb_pkg::CUBE_EDGE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [vfbpb_pkg::KIND_W-1:0]     i_kind,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_x,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_y,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_z,
    input  logic [vfbpb_pkg::VI_W-1:0]       i_voxel_index,
    input  logic [vfbpb_pkg::AXIS_W-1:0]     i_axis,
    input  logic [vfbpb_pkg::COORD_W-1:0]    i_plane_index,
    input  logic [vfbpb_pkg::POS_W-1:0]      i_plane_position,
    input  logic [vfbpb_pkg::COLOR_W-1:0]    i_color,
    input  logic [vfbpb_pkg::MODE_W-1:0]     i_blend_mode,
    input  logic [vfbpb_pkg::BSIZE_W-1:0]    i_block_size,
    input  logic [vfbpb_pkg::PARTS_W-1:0]    i_draw_parts,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [vfbpb_pkg::COLOR_W-1:0]    o_voxel_color
);
    import vfbpb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing
    vfbpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // store and sweep
    vfbpb_dp #(
        .CUBE_EDGE (CUBE_EDGE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_kind           (i_kind),
        .i_x              (i_x),
        .i_y              (i_y),
        .i_z              (i_z),
        .i_voxel_index    (i_voxel_index),
        .i_axis           (i_axis),
        .i_plane_index    (i_plane_index),
        .i_plane_position (i_plane_position),
        .i_color          (i_color),
        .i_blend_mode     (i_blend_mode),
        .i_block_size     (i_block_size),
        .i_draw_parts     (i_draw_parts),
        .o_voxel_color    (o_voxel_color)
    );

endmodule

[src/vfbpb_chk.sv]
// Port-level checker for the voxel frame buffer, bound to the top level.
// Depends on vfbpb_pkg and voxel_frame_buffer_plane_blend_defines.svh.
`timescale 1ns / 1ps
`include "voxel_frame_buffer_plane_blend_defines.svh"

module vfbpb_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [vfbpb_pkg::COLOR_W-1:0] o_voxel_color
);
    import vfbpb_pkg::*;

    // a waiting result beat stays up
    `VFBPB_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result beat dropped before taken")
    // and keeps its value
    `VFBPB_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_voxel_color), "stalled result changed")
    // one item at a time: no new input while a result waits
    `VFBPB_NEVER(a_ready_during_result, i_clk, i_rst_n, o_out_valid && o_in_ready, "input ready while result pending")
    // an accepted beat starts a sweep, so ready drops
    `VFBPB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready right after accept")
    // clearing pass runs after reset
    `VFBPB_ASSERT(a_clear_after_reset, i_clk, i_rst_n, $rose(i_rst_n) |=> !o_in_ready, "ready during reset clearing pass")

endmodule

bind voxel_frame_buffer_plane_blend vfbpb_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_voxel_color (o_voxel_color)
);

[bench/voxel_frame_buffer_plane_blend_check.sv]
// Checker for the voxel frame buffer: watches both channels, keeps its own voxel store,
// predicts the read results and compares them with the output beats.
// Depends on vfbpb_pkg for field widths, item kinds, blend modes and axes.
`timescale 1ns / 1ps

module voxel_frame_buffer_plane_blend_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [vfbpb_pkg::KIND_W-1:0]  i_kind,
    input  logic [vfbpb_pkg::COORD_W-1:0] i_x,
    input  logic [vfbpb_pkg::COORD_W-1:0] i_y,
    input  logic [vfbpb_pkg::COORD_W-1:0] i_z,
    input  logic [vfbpb_pkg::VI_W-1:0]    i_voxel_index,
    input  logic [vfbpb_pkg::AXIS_W-1:0]  i_axis,
    input  logic [vfbpb_pkg::COORD_W-1:0] i_plane_index,
    input  logic [vfbpb_pkg::POS_W-1:0]   i_plane_position,
    input  logic [vfbpb_pkg::COLOR_W-1:0] i_color,
    input  logic [vfbpb_pkg::MODE_W-1:0]  i_blend_mode,
    input  logic [vfbpb_pkg::BSIZE_W-1:0] i_block_size,
    input  logic [vfbpb_pkg::PARTS_W-1:0] i_draw_parts,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [vfbpb_pkg::COLOR_W-1:0] i_voxel_color,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_reads_checked
);
    import vfbpb_pkg::*;

    localparam int EDGE   = CUBE_EDGE_DEF;
    localparam int VOXELS = EDGE * EDGE * EDGE;

    // Predicted contents of the frame store
    logic [COLOR_W-1:0] voxel_mem [0:VOXELS-1];
    // Colors that read beats are still owed
    logic [COLOR_W-1:0] owed_colors [$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_reads_checked = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        o_fail_count++;
    endtask

    function automatic int voxel_addr(input int vx, input int vy, input int vz);
        return vx + EDGE * vy + EDGE * EDGE * vz;
    endfunction

    // Plane coordinates (u, v) are the two axes other than the normal, lower one first
    function automatic int plane_addr(input logic [AXIS_W-1:0] axis, input int k,
                                      input int u, input int v);
        case (axis)
            AXIS_X:  return voxel_addr(k, u, v);
            AXIS_Y:  return voxel_addr(u, k, v);
            default: return voxel_addr(u, v, k);
        endcase
    endfunction

    task automatic blend_into(input int addr, input logic [COLOR_W-1:0] color,
                              input logic [MODE_W-1:0] mode);
        case (mode)
            MODE_REPLACE: voxel_mem[addr] = color;
            MODE_MASK:    if (color != '0) voxel_mem[addr] = color;
            MODE_AND:     voxel_mem[addr] = voxel_mem[addr] & color;
            default:      voxel_mem[addr] = voxel_mem[addr] | color;
        endcase
    endtask

    // Centered block; class by count of coordinates on the block boundary
    task automatic draw_block(input int size, input logic [COLOR_W-1:0] color,
                              input logic [PARTS_W-1:0] parts);
        int lo;
        int hi;
        int n;
        logic on;
        if (size == 0) return;
        lo = EDGE / 2 - (size - 1);
        hi = EDGE / 2 + (size - 1);
        for (int vz = lo; vz <= hi; vz++)
            for (int vy = lo; vy <= hi; vy++)
                for (int vx = lo; vx <= hi; vx++) begin
                    if (vx < 0 || vy < 0 || vz < 0 || vx >= EDGE || vy >= EDGE || vz >= EDGE)
                        continue;
                    n = int'(vx == lo || vx == hi) + int'(vy == lo || vy == hi)
                      + int'(vz == lo || vz == hi);
                    if (n >= 2)      on = parts[PART_EDGE];
                    else if (n == 1) on = parts[PART_FACE];
                    else             on = parts[PART_INNER];
                    if (on) voxel_mem[voxel_addr(vx, vy, vz)] = color;
                end
    endtask

    // Update the store for one accepted input beat; queue the color for reads
    task automatic apply_beat();
        logic xyz_ok;
        logic idx_ok;
        logic plane_ok;
        int   pos;
        xyz_ok   = i_x < EDGE && i_y < EDGE && i_z < EDGE;
        idx_ok   = i_voxel_index < VOXELS;
        plane_ok = (i_axis == AXIS_X || i_axis == AXIS_Y || i_axis == AXIS_Z)
                && i_plane_index < EDGE;
        pos      = i_plane_position;
        case (i_kind)
            KIND_CLEAR:
                for (int i = 0; i < VOXELS; i++) voxel_mem[i] = '0;
            KIND_WR_XYZ:
                if (xyz_ok) voxel_mem[voxel_addr(i_x, i_y, i_z)] = i_color;
            KIND_WR_IDX:
                if (idx_ok) voxel_mem[i_voxel_index] = i_color;
            KIND_RD_XYZ:
                owed_colors.push_back(xyz_ok ? voxel_mem[voxel_addr(i_x, i_y, i_z)] : '0);
            KIND_RD_IDX:
                owed_colors.push_back(idx_ok ? voxel_mem[i_voxel_index] : '0);
            KIND_PLANE_FILL:
                if (plane_ok)
                    for (int v = 0; v < EDGE; v++)
                        for (int u = 0; u < EDGE; u++)
                            blend_into(plane_addr(i_axis, i_plane_index, u, v),
                                       i_color, i_blend_mode);
            KIND_PLANE_ELEM:
                if (plane_ok && pos < EDGE * EDGE)
                    blend_into(plane_addr(i_axis, i_plane_index, pos % EDGE, pos / EDGE),
                               i_color, i_blend_mode);
            default:
                draw_block(i_block_size, i_color, i_draw_parts);
        endcase
    endtask

    // Result beats first: a beat accepted on this edge cannot have a result yet
    always @(posedge i_clk) begin : watch
        logic [COLOR_W-1:0] want;
        if (!i_rst_n) begin
            for (int i = 0; i < VOXELS; i++) voxel_mem[i] = '0;
            owed_colors.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_colors.size() == 0) begin
                    report_mismatch($sformatf("result beat %02h with no read pending",
                                              i_voxel_color));
                end else begin
                    want = owed_colors.pop_front();
                    o_reads_checked++;
                    if (i_voxel_color !== want)
                        report_mismatch($sformatf("voxel_color got %02h expected %02h",
                                                  i_voxel_color, want));
                end
            end
            if (i_in_valid && i_in_ready) apply_beat();
        end
        o_pending = owed_colors.size();
    end

endmodule

[bench/voxel_frame_buffer_plane_blend_test.sv]
// Top of the voxel frame buffer bench: clock, reset, directed and random input beats,
// random output stalls, a stall watchdog and the verdict.
// Depends on vfbpb_pkg, voxel_frame_buffer_plane_blend and voxel_frame_buffer_plane_blend_check.
`timescale 1ns / 1ps

module voxel_frame_buffer_plane_blend_test;
    import vfbpb_pkg::*;

    localparam int RANDOM_BEATS = 1600;
    localparam int SWEEP_CYCLES = CUBE_EDGE_DEF ** 3 + 2;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [VI_W-1:0]    voxel_index;
        logic [AXIS_W-1:0]  axis;
        logic [COORD_W-1:0] plane_index;
        logic [POS_W-1:0]   plane_position;
        logic [COLOR_W-1:0] color;
        logic [MODE_W-1:0]  blend_mode;
        logic [BSIZE_W-1:0] block_size;
        logic [PARTS_W-1:0] draw_parts;
    } t_beat;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    t_beat              in_beat   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COLOR_W-1:0] voxel_color;
    logic               calm      = 1'b0;   // no idling on either side
    int                 beats_sent = 0;
    int                 stall_cycles = 0;
    int                 fail_count;
    int                 pending;
    int                 reads_checked;

    voxel_frame_buffer_plane_blend i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_kind           (in_beat.kind),
        .i_x              (in_beat.x),
        .i_y              (in_beat.y),
        .i_z              (in_beat.z),
        .i_voxel_index    (in_beat.voxel_index),
        .i_axis           (in_beat.axis),
        .i_plane_index    (in_beat.plane_index),
        .i_plane_position (in_beat.plane_position),
        .i_color          (in_beat.color),
        .i_blend_mode     (in_beat.blend_mode),
        .i_block_size     (in_beat.block_size),
        .i_draw_parts     (in_beat.draw_parts),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_voxel_color    (voxel_color)
    );

    voxel_frame_buffer_plane_blend_check i_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_kind           (in_beat.kind),
        .i_x              (in_beat.x),
        .i_y              (in_beat.y),
        .i_z              (in_beat.z),
        .i_voxel_index    (in_beat.voxel_index),
        .i_axis           (in_beat.axis),
        .i_plane_index    (in_beat.plane_index),
        .i_plane_position (in_beat.plane_position),
        .i_color          (in_beat.color),
        .i_blend_mode     (in_beat.blend_mode),
        .i_block_size     (in_beat.block_size),
        .i_draw_parts     (in_beat.draw_parts),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_voxel_color    (voxel_color),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_reads_checked  (reads_checked)
    );

    // 20 ns clock
    initial begin
        forever #10 clk = ~clk;
    end

    // Receiver drops ready at random, with a 17 percent chance, unless calm
    always @(negedge clk) begin
        out_ready <= calm || ($urandom_range(99) >= 17);
    end

    // Watchdog: cycles with no beat moving on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", stall_cycles);
                $display("voxel_frame_buffer_plane_blend_test NOT OK");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Random-content beat with every field drawn over its full width
    function automatic t_beat noise_beat();
        t_beat b;
        b = '0;
        b.kind           = KIND_W'($urandom_range(7));
        b.x              = COORD_W'($urandom_range(7));
        b.y              = COORD_W'($urandom_range(7));
        b.z              = COORD_W'($urandom_range(7));
        b.voxel_index    = VI_W'($urandom_range(127));
        b.axis           = AXIS_W'($urandom_range(3));
        b.plane_index    = COORD_W'($urandom_range(7));
        b.plane_position = POS_W'($urandom_range(31));
        b.color          = COLOR_W'($urandom_range(255));
        b.blend_mode     = MODE_W'($urandom_range(3));
        b.block_size     = BSIZE_W'($urandom_range(3));
        b.draw_parts     = PARTS_W'($urandom_range(7));
        return b;
    endfunction

    // Mostly in range, sometimes past the cube
    function automatic int pick(input int in_hi, input int full_hi);
        return ($urandom_range(99) < 90) ? $urandom_range(in_hi) : $urandom_range(full_hi);
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        int r;
        r = $urandom_range(99);
        if (r < 15) return '0;
        if (r < 25) return '1;
        return COLOR_W'($urandom_range(255));
    endfunction

    // Present one input beat, with an optional idle gap first, and wait for accept
    task automatic send_beat(input t_beat b);
        int gap;
        gap = 0;
        @(negedge clk);
        if (!calm) begin
            while ($urandom_range(99) < 17) gap++;
            // long gap now and then so valid rises at any point of a sweep
            if ($urandom_range(99) < 8) gap += $urandom_range(SWEEP_CYCLES + 10, 20);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_beat  <= b;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    // Single-voxel access: kinds that use coordinates or the linear index; also sends clears
    task automatic do_voxel(input logic [KIND_W-1:0] kind, input int vx, input int vy,
                            input int vz, input int vi, input logic [COLOR_W-1:0] color);
        t_beat b;
        b = noise_beat();
        b.kind = kind;
        b.x = COORD_W'(vx);
        b.y = COORD_W'(vy);
        b.z = COORD_W'(vz);
        b.voxel_index = VI_W'(vi);
        b.color = color;
        send_beat(b);
    endtask

    task automatic do_plane(input logic [KIND_W-1:0] kind, input int axis, input int k,
                            input int pos, input logic [COLOR_W-1:0] color,
                            input logic [MODE_W-1:0] mode);
        t_beat b;
        b = noise_beat();
        b.kind = kind;
        b.axis = AXIS_W'(axis);
        b.plane_index = COORD_W'(k);
        b.plane_position = POS_W'(pos);
        b.color = color;
        b.blend_mode = mode;
        send_beat(b);
    endtask

    task automatic do_block(input int size, input logic [PARTS_W-1:0] parts,
                            input logic [COLOR_W-1:0] color);
        t_beat b;
        b = noise_beat();
        b.kind = KIND_BLOCK;
        b.block_size = BSIZE_W'(size);
        b.draw_parts = parts;
        b.color = color;
        send_beat(b);
    endtask

    initial begin
        int r;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every kind and blend mode, out-of-range fields
        do_voxel(KIND_RD_IDX, 0, 0, 0, 62, 8'h00);
        do_voxel(KIND_WR_XYZ, 4, 4, 4, 0, 8'hFF);
        do_voxel(KIND_RD_XYZ, 4, 4, 4, 0, 8'h00);
        do_voxel(KIND_WR_IDX, 7, 7, 7, 0, 8'h01);
        do_voxel(KIND_WR_IDX, 0, 0, 0, 124, 8'hA5);
        do_voxel(KIND_RD_IDX, 0, 0, 0, 124, 8'h00);
        do_voxel(KIND_WR_XYZ, 7, 0, 0, 0, 8'h55);
        do_voxel(KIND_WR_IDX, 0, 0, 0, 127, 8'h66);
        do_voxel(KIND_RD_XYZ, 7, 7, 7, 0, 8'h00);
        do_voxel(KIND_RD_IDX, 0, 0, 0, 125, 8'h00);
        do_plane(KIND_PLANE_FILL, AXIS_X, 0, 0, 8'h3C, MODE_REPLACE);
        do_plane(KIND_PLANE_FILL, AXIS_Y, 4, 0, 8'h00, MODE_MASK);
        do_plane(KIND_PLANE_FILL, AXIS_Z, 2, 0, 8'h0F, MODE_AND);
        do_plane(KIND_PLANE_FILL, AXIS_X, 4, 0, 8'hF0, MODE_OR);
        do_plane(KIND_PLANE_ELEM, AXIS_Y, 1, 24, 8'h81, MODE_REPLACE);
        do_plane(KIND_PLANE_ELEM, AXIS_Z, 3, 0, 8'h00, MODE_MASK);
        do_plane(KIND_PLANE_FILL, 3, 1, 0, 8'hFF, MODE_REPLACE);
        do_plane(KIND_PLANE_ELEM, AXIS_X, 7, 3, 8'hFF, MODE_REPLACE);
        do_plane(KIND_PLANE_ELEM, AXIS_Z, 2, 31, 8'hFF, MODE_REPLACE);
        do_block(1, 3'b001, 8'h77);
        do_voxel(KIND_RD_IDX, 0, 0, 0, 62, 8'h00);
        do_block(3, 3'b111, 8'h5A);
        do_block(2, 3'b010, 8'hC3);
        do_block(3, 3'b100, 8'h18);
        do_block(0, 3'b111, 8'hEE);
        do_voxel(KIND_RD_XYZ, 1, 1, 1, 0, 8'h00);
        do_voxel(KIND_CLEAR, 0, 0, 0, 0, 8'h00);
        do_voxel(KIND_RD_IDX, 0, 0, 0, 124, 8'h00);

        // Random: reads weighted up, rare clears so the store fills
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            calm = (n >= 700 && n < 1000);
            r = $urandom_range(99);
            if (r < 3)
                do_voxel(KIND_CLEAR, 0, 0, 0, 0, 8'h00);
            else if (r < 18)
                do_voxel(KIND_WR_XYZ, pick(4, 7), pick(4, 7), pick(4, 7), 0, pick_color());
            else if (r < 30)
                do_voxel(KIND_WR_IDX, 0, 0, 0, pick(124, 127), pick_color());
            else if (r < 52)
                do_voxel(KIND_RD_XYZ, pick(4, 7), pick(4, 7), pick(4, 7), 0, 8'h00);
            else if (r < 72)
                do_voxel(KIND_RD_IDX, 0, 0, 0, pick(124, 127), 8'h00);
            else if (r < 82)
                do_plane(KIND_PLANE_FILL, pick(2, 3), pick(4, 7), 0, pick_color(),
                         MODE_W'($urandom_range(3)));
            else if (r < 92)
                do_plane(KIND_PLANE_ELEM, pick(2, 3), pick(4, 7), pick(24, 31), pick_color(),
                         MODE_W'($urandom_range(3)));
            else
                do_block(($urandom_range(99) < 90) ? $urandom_range(3, 1) : 0,
                         PARTS_W'($urandom_range(7)), pick_color());
        end
        calm = 1'b0;
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain the owed reads, then let any sweep in flight finish
        wait (pending == 0);
        repeat (2 * SWEEP_CYCLES) @(posedge clk);

        $display("Sent %0d input beats over all item kinds, blend modes and out-of-range fields;",
                 beats_sent);
        $display("checked %0d read results against the predicted store.", reads_checked);
        if (fail_count == 0 && pending == 0) begin
            $display("voxel_frame_buffer_plane_blend_test OK");
        end else begin
            $display("voxel_frame_buffer_plane_blend_test NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/vfbpb_pkg.sv
src/vfbpb_dp.sv
src/vfbpb_ctrl.sv
src/voxel_frame_buffer_plane_blend.sv
src/vfbpb_chk.sv
bench/voxel_frame_buffer_plane_blend_check.sv
bench/voxel_frame_buffer_plane_blend_test.sv
